>>> hdl/wdc_pkg.sv
// Package: payload words, configuration types and register indexes for the wake confirmer.
`timescale 1ns / 1ps
package wdc_pkg;

  localparam int SEQ_W  = 32;
  localparam int GEN_W  = 32;
  localparam int TS_W   = 62;
  localparam int DL_W   = 63;
  localparam int STEP_W = 8;
  localparam int QP_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_PERIOD = 2'd1;

  localparam logic [STEP_W-1:0] WINDOW_STEP_RESET = 8'd5;
  localparam logic [QP_W-1:0]   QUIET_PERIOD_RESET = 32'd3000000;

  typedef struct packed {
    logic              positive;
    logic [GEN_W-1:0]  session_generation;
    logic [SEQ_W-1:0]  window_sequence;
    logic [TS_W-1:0]   timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic alert;
    logic confirming;
  } out_word_t;

  typedef struct packed {
    logic [STEP_W-1:0] window_step;
    logic [QP_W-1:0]   quiet_period_us;
  } cfg_t;

endpackage

>>> hdl/wdc_cfg.sv
// Configuration register file: window step and quiet period.
`timescale 1ns / 1ps
module wdc_cfg import wdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_step     <= WINDOW_STEP_RESET;
      cfg.quiet_period_us <= QUIET_PERIOD_RESET;
    end else if (cfg_valid) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        CFG_WINDOW_STEP:  cfg.window_step     <= cfg_data[STEP_W-1:0];
        CFG_QUIET_PERIOD: cfg.quiet_period_us <= cfg_data[QP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/wdc_core.sv
// Confirmation state and the single-pass decision logic for one window word.
`timescale 1ns / 1ps
module wdc_core import wdc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t result
);

  logic             phase_confirming;
  logic [GEN_W-1:0] seen_generation;
  logic [SEQ_W-1:0] previous_sequence;
  logic [DL_W-1:0]  quiet_deadline_us;

  logic             phase_next;
  logic [DL_W-1:0]  quiet_deadline_us_next;
  logic             gen_change;
  logic             seq_gap;
  logic             phase_mid;
  logic [DL_W-1:0]  deadline_mid;
  logic [SEQ_W-1:0] expected_seq;
  logic [DL_W-1:0]  now_ext;
  logic             fire;

  assign gen_change   = item.session_generation != seen_generation;
  assign expected_seq = previous_sequence + SEQ_W'(cfg.window_step);
  assign seq_gap      = (previous_sequence != '0) && (item.window_sequence != expected_seq);
  assign now_ext      = {1'b0, item.timestamp_us};

  always_comb begin
    phase_mid    = phase_confirming;
    deadline_mid = quiet_deadline_us;
    if (gen_change) begin
      phase_mid    = 1'b0;
      deadline_mid = '0;
    end else if (seq_gap) begin
      phase_mid = 1'b0;
    end

    fire                   = 1'b0;
    phase_next             = phase_mid;
    quiet_deadline_us_next = deadline_mid;
    priority if (!item.positive) begin
      phase_next = 1'b0;
    end else if (!phase_mid) begin
      phase_next = 1'b1;
    end else if (now_ext >= deadline_mid) begin
      quiet_deadline_us_next = now_ext + DL_W'(cfg.quiet_period_us);
      phase_next             = 1'b0;
      fire                   = 1'b1;
    end
  end

  assign result.alert      = fire;
  assign result.confirming = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_confirming  <= 1'b0;
      seen_generation   <= '0;
      previous_sequence <= '0;
      quiet_deadline_us <= '0;
    end else if (advance) begin
      phase_confirming  <= phase_next;
      seen_generation   <= item.session_generation;
      previous_sequence <= item.window_sequence;
      quiet_deadline_us <= quiet_deadline_us_next;
    end
  end

  // a fired alert arms the deadline from this window's time
  a_deadline_armed: assert property (@(posedge clk) disable iff (rst)
    advance && fire |=> quiet_deadline_us ==
      $past(now_ext + DL_W'(cfg.quiet_period_us)))
    else $error("quiet deadline not armed after alert");

  // a new session starts clean: phase follows the positive flag only
  a_gen_restart: assert property (@(posedge clk) disable iff (rst)
    advance && gen_change |-> !fire && (phase_next == item.positive))
    else $error("session change did not restart confirmation");

endmodule

>>> hdl/wake_detection_confirmer_top.sv
// Top level of the wake confirmer: input register, decision core, output register, config.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------
//   in      | in        | in_valid / in_stall  | in_data  (in_word_t)
//   out     | out       | out_valid / out_stall| out_data (out_word_t)
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while out_stall stays low. out_valid rises once the word
// has passed both registers: the word sits in the input register, and when the output
// register is free the decision and state update land in the output register.
// The state update and the result are produced in the same edge, so words follow
// back to back. Reset (rst, synchronous) clears state, valids and config defaults.
// A stalled output holds its word; the input register keeps taking a word as long
// as the output register frees up in the same cycle. cfg_ready is always high.
`timescale 1ns / 1ps
module wake_detection_confirmer_top import wdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  in_word_t  hold;
  logic      hold_valid;
  logic      out_free;
  logic      advance;
  logic      take_in;
  out_word_t result;
  cfg_t      cfg;

  assign cfg_ready = 1'b1;

  // output slot frees when empty or being taken this edge
  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;
  assign take_in  = in_valid && !in_stall;

  wdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wdc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take_in) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
    if (take_in) begin
      hold <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // an alert always returns the phase to listening
  a_alert_listen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.alert && out_data.confirming))
    else $error("alert reported while still confirming");

  // a word moved into the output slot shows up there next cycle
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && (out_data == $past(result)))
    else $error("advanced word lost at output register");

endmodule
